// File: design/rgbe_pixel_codec_assert.svh
// assertion macros used by the rgbe pixel codec top level
// expects clk and rst_n in the scope of each use
`ifndef RGBE_PIXEL_CODEC_ASSERT_SVH
`define RGBE_PIXEL_CODEC_ASSERT_SVH

// same-cycle implication
`define RGBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rgbe_pkg.sv
// package for the rgbe pixel codec: status codes, merge struct, constants
// no dependencies
package rgbe_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_SAT   = 2'd2,
    ST_CLAMP = 2'd3
  } status_t;

  typedef enum logic {
    ACT_DECODE = 1'b0,
    ACT_ENCODE = 1'b1
  } action_t;

  localparam int unsigned NUM_LANES = 3;

  // smallest positive float bit pattern not below 1e-32
  localparam logic [30:0] TINY_BITS = 31'h0A4F_B11F;
  localparam logic [7:0]  EXP_SAT   = 8'd254;

  typedef struct packed {
    logic       sat;
    logic       below;
    logic       clamped;
    logic [7:0] maxexp;
  } merge_t;

endpackage

// File: design/rgbe_lane_front.sv
// per-channel front lane: rgbe byte decode and float clean-up
// depends on nothing
module rgbe_lane_front (
  input  logic [7:0]  mant,
  input  logic [7:0]  shared_exp,
  input  logic [31:0] fbits,
  output logic [31:0] dec,
  output logic [30:0] clean,
  output logic        clamped
);

  logic [8:0]  v;
  logic [3:0]  p;
  logic [8:0]  psum;
  logic [8:0]  sub_sh;
  logic [31:0] v_ext;
  logic [31:0] norm_sh;
  logic [7:0]  nexp;
  logic        is_nan;
  logic        is_neg;

  assign v     = {mant, 1'b1};
  assign v_ext = {23'd0, v};

  always_comb begin
    p = 4'd0;
    for (int i = 1; i < 9; i++) begin
      if (v[i]) p = 4'(i);
    end
  end

  assign psum    = {5'd0, p} + {1'b0, shared_exp};
  assign sub_sh  = {1'b0, shared_exp} + 9'd12;
  assign norm_sh = v_ext << (5'd23 - {1'b0, p});
  assign nexp    = 8'(psum - 9'd10);

  always_comb begin
    if (psum >= 9'd11) begin
      dec = {1'b0, nexp, norm_sh[22:0]};
    end else begin
      dec = v_ext << sub_sh[4:0];
    end
  end

  assign is_nan  = (fbits[30:23] == 8'hFF) && (fbits[22:0] != 23'd0);
  assign is_neg  = fbits[31] && (fbits[30:0] != 31'd0);
  assign clamped = is_nan || is_neg;
  assign clean   = clamped ? 31'd0 : fbits[30:0];

endmodule

// File: design/rgbe_merge.sv
// merging stage: maximum of the cleaned lanes and the pixel-wide flags
// depends on rgbe_pkg
module rgbe_merge (
  input  logic [30:0]         c0,
  input  logic [30:0]         c1,
  input  logic [30:0]         c2,
  input  logic [2:0]          clamp_in,
  output rgbe_pkg::merge_t    info
);

  logic [30:0] m01;
  logic [30:0] mx;

  assign m01 = (c1 > c0) ? c1 : c0;
  assign mx  = (c2 > m01) ? c2 : m01;

  always_comb begin
    info.maxexp  = mx[30:23];
    info.sat     = mx[30:23] >= rgbe_pkg::EXP_SAT;
    info.below   = mx < rgbe_pkg::TINY_BITS;
    info.clamped = |clamp_in;
  end

endmodule

// File: design/rgbe_lane_back.sv
// per-channel back lane: mantissa byte from a cleaned float and the shared exponent
// depends on nothing
module rgbe_lane_back (
  input  logic [30:0] clean,
  input  logic [7:0]  maxexp,
  output logic [7:0]  mant
);

  logic [7:0]  ex;
  logic [23:0] sig;
  logic [8:0]  sh;
  logic [23:0] shifted;

  assign ex      = (clean[30:23] == 8'd0) ? 8'd1 : clean[30:23];
  assign sig     = {clean[30:23] != 8'd0, clean[22:0]};
  assign sh      = {1'b0, maxexp} - {1'b0, ex} + 9'd16;
  assign shifted = sig >> sh[4:0];
  assign mant    = (sh >= 9'd32) ? 8'd0 : shifted[7:0];

endmodule

// File: design/rgbe_pixel_codec.sv
// top level of the rgbe pixel codec: two-stage pipeline over three color lanes
// depends on rgbe_pkg, rgbe_lane_front, rgbe_merge, rgbe_lane_back
//
// one pixel per item on each channel. in_tuser selects the direction
// (0 decode rgbe bytes to floats, 1 encode floats to rgbe), in_tlast marks
// the last pixel of an image and comes back on out_tlast.
// stage one runs the three front lanes (decode, clean-up) and the merge of
// the maximum; stage two runs the three back lanes (mantissa shift) and
// forms the result register. an accepted item passes the stage-one and
// then the stage-two register before out_tvalid. throughput is one item
// per cycle unless stalled, set by the single pass through each stage.
// each stage holds while its successor is full and stalled, so a stalled
// receiver fills both stages and then drops in_tready; nothing is lost.
// out_tuser carries the status code (0 ok, 1 zeroed, 2 saturated, 3 clamped).
// reset (rst_n low, synchronous) empties both stages.
`include "rgbe_pixel_codec_assert.svh"
module rgbe_pixel_codec (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mant_red, mant_green, mant_blue, shared_exp, float_red, float_green, float_blue
  input  logic [127:0] in_tdata,
  // action
  input  logic [0:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // dec_red, dec_green, dec_blue, enc_red, enc_green, enc_blue, enc_exp
  output logic [127:0] out_tdata,
  // status
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  logic [31:0] dec_w   [3];
  logic [30:0] clean_w [3];
  logic [2:0]  clamp_w;
  logic [7:0]  enc_w   [3];
  rgbe_pkg::merge_t info_w;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_act_r;
  logic        s1_last_r;
  logic [31:0] s1_dec_r   [3];
  logic [30:0] s1_clean_r [3];
  rgbe_pkg::merge_t s1_info_r;

  logic        s2_valid_r, s2_valid_nxt;
  logic        s2_ready;
  logic [127:0] s2_data_r, s2_data_nxt;
  logic [1:0]   s2_stat_r, s2_stat_nxt;
  logic         s2_last_r;

  for (genvar g = 0; g < rgbe_pkg::NUM_LANES; g++) begin : g_lane
    rgbe_lane_front u_front (
      .mant       (in_tdata[8*g +: 8]),
      .shared_exp (in_tdata[31:24]),
      .fbits      (in_tdata[32 + 32*g +: 32]),
      .dec        (dec_w[g]),
      .clean      (clean_w[g]),
      .clamped    (clamp_w[g])
    );
    rgbe_lane_back u_back (
      .clean  (s1_clean_r[g]),
      .maxexp (s1_info_r.maxexp),
      .mant   (enc_w[g])
    );
  end

  rgbe_merge u_merge (
    .c0       (clean_w[0]),
    .c1       (clean_w[1]),
    .c2       (clean_w[2]),
    .clamp_in (clamp_w),
    .info     (info_w)
  );

  assign s2_ready  = !s2_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;

  assign s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;
  assign s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;

  always_comb begin
    s2_data_nxt = '0;
    s2_stat_nxt = rgbe_pkg::ST_OK;
    if (s1_act_r == rgbe_pkg::ACT_DECODE) begin
      s2_data_nxt[95:0] = {s1_dec_r[2], s1_dec_r[1], s1_dec_r[0]};
    end else if (s1_info_r.sat) begin
      s2_data_nxt[127:96] = 32'hFFFF_FFFF;
      s2_stat_nxt = rgbe_pkg::ST_SAT;
    end else if (s1_info_r.below) begin
      s2_stat_nxt = s1_info_r.clamped ? rgbe_pkg::ST_CLAMP : rgbe_pkg::ST_ZERO;
    end else begin
      s2_data_nxt[127:96] = {8'(s1_info_r.maxexp + 8'd2), enc_w[2], enc_w[1], enc_w[0]};
      s2_stat_nxt = s1_info_r.clamped ? rgbe_pkg::ST_CLAMP : rgbe_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_act_r   <= in_tuser[0];
      s1_last_r  <= in_tlast;
      s1_dec_r   <= dec_w;
      s1_clean_r <= clean_w;
      s1_info_r  <= info_w;
    end
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
      s2_stat_r <= s2_stat_nxt;
      s2_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = s2_data_r;
  assign out_tuser  = s2_stat_r;
  assign out_tlast  = s2_last_r;

  `RGBE_ASSERT_NXT(a_s1_moves, s1_valid_r && s2_ready, s2_valid_r, "stage one item lost")
  `RGBE_ASSERT_IMP(a_stall_full, !in_tready, s1_valid_r && s2_valid_r, "ready low while not full")
  `RGBE_ASSERT_IMP(a_sat_bytes, out_tvalid && out_tuser == rgbe_pkg::ST_SAT,
    out_tdata[127:96] == 32'hFFFF_FFFF, "saturated pixel without 255 bytes")
  `RGBE_ASSERT_IMP(a_zero_bytes, out_tvalid && out_tuser == rgbe_pkg::ST_ZERO,
    out_tdata == 128'd0, "zeroed pixel with nonzero bytes")

endmodule
